FILE: rtl/feg_pkg.sv
// ----------------------------------------------------------------------------
// feg_pkg
// Shared constants and types for the fire-escape grid search block.
// ----------------------------------------------------------------------------
package feg_pkg;

  localparam int MAX_SIDE_DEF = 1024;

  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int TIME_W     = 21;
  localparam int KIND_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS = 1'd1;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_EMPTY  = 2'd0;
  localparam kind_t KIND_WALL   = 2'd1;
  localparam kind_t KIND_SOURCE = 2'd2;
  localparam kind_t KIND_START  = 2'd3;

endpackage

FILE: rtl/feg_if.sv
// ----------------------------------------------------------------------------
// feg_if
// Valid/ready channels: grid cells in, search result out.
// ----------------------------------------------------------------------------
interface feg_in_if;
  import feg_pkg::*;
  logic  valid;
  logic  ready;
  kind_t cell_kind;
  logic  last_cell;

  modport source (output valid, output cell_kind, output last_cell, input ready);
  modport sink   (input valid, input cell_kind, input last_cell, output ready);
endinterface

interface feg_out_if;
  import feg_pkg::*;
  logic              valid;
  logic              ready;
  logic              escaped;
  logic [TIME_W-1:0] escape_time;

  modport source (output valid, output escaped, output escape_time, input ready);
  modport sink   (input valid, input escaped, input escape_time, output ready);
endinterface

FILE: rtl/feg_ram.sv
// ----------------------------------------------------------------------------
// feg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module feg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/fire_escape_grid_bfs_top.sv
// ----------------------------------------------------------------------------
// fire_escape_grid_bfs_top
// Grid loader plus two breadth-first searches (hazard spread, then walker).
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one grid cell per beat in row-major order; last_cell ends
//   the grid. Cells load at one per cycle. After the last cell the block
//   drops in_ready and runs: a clearing sweep of the two time RAMs over
//   all rows*cols cells, a seeding sweep per search, and the searches
//   themselves; the single read port of each RAM sets their pace.
//   out_ch then shows one result beat: escaped and the 1-based exit time.
//   The result is held until out_ready; only after that beat is taken does
//   in_ready rise again for the next grid.
//   cfg_we/cfg_addr/cfg_wdata write grid_rows (index 0) and grid_cols
//   (index 1); only while the block is idle, which the user must ensure.
//   Synchronous active-low reset returns to loading, empty grid count, both
//   sizes set to 1. The RAMs are not cleared by reset.
// ----------------------------------------------------------------------------
module fire_escape_grid_bfs_top #(
  parameter int MAX_SIDE = feg_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  feg_in_if.sink                         in_ch,
  feg_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [feg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [feg_pkg::CFG_W-1:0]      cfg_wdata
);
  import feg_pkg::*;

  localparam int AW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = 2 * AW;
  localparam int CW    = IW + 1;
  localparam int TW    = IW + 1;
  localparam int QW    = 2 * AW;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_SEED_RD  = 4'd2;
  localparam logic [3:0] S_SEED_CHK = 4'd3;
  localparam logic [3:0] S_POP      = 4'd4;
  localparam logic [3:0] S_POP_W    = 4'd5;
  localparam logic [3:0] S_IDX      = 4'd6;
  localparam logic [3:0] S_CUR_RD   = 4'd7;
  localparam logic [3:0] S_CUR_W    = 4'd8;
  localparam logic [3:0] S_NB       = 4'd9;
  localparam logic [3:0] S_NB_RD    = 4'd10;
  localparam logic [3:0] S_NB_CHK   = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic [CW-1:0]    load_pos_r, load_pos_nxt;
  logic [CFG_W-1:0] rows_r, cols_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic             walker_r, walker_nxt;
  logic [CW-1:0]    seed_i_r, seed_i_nxt;
  logic [1:0]       dir_r, dir_nxt;

  // payload state
  logic [SW-1:0]     r_r, r_nxt, c_r, c_nxt;
  logic [CW-1:0]     n_r, n_nxt, loaded_r, loaded_nxt;
  logic [AW-1:0]     srow_r, srow_nxt, scol_r, scol_nxt;
  logic [AW-1:0]     cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [IW-1:0]     cur_idx_r, cur_idx_nxt;
  logic [TW-1:0]     cur_time_r, cur_time_nxt;
  logic [IW-1:0]     ni_r, ni_nxt;
  logic [AW-1:0]     nr_r, nr_nxt, nc_r, nc_nxt;
  logic              out_esc_r, out_esc_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;

  // RAM ports
  logic          cell_we;
  logic [IW-1:0] cell_waddr;
  kind_t         cell_wdata, cell_rdata;
  logic          hz_we, wk_we;
  logic [IW-1:0] tm_waddr;
  logic [TW-1:0] tm_wdata, hz_rdata, wk_rdata;
  logic [IW-1:0] rd_addr;
  logic          q_we;
  logic [QW-1:0] q_wdata, q_rdata;

  logic [SW-1:0] rows_cl, cols_cl;
  logic [CW-1:0] n_now, pos_after;
  logic          in_acc, out_acc;
  logic          border;
  logic          nb_out;
  kind_t         seed_kind, nb_kind;
  logic [TW-1:0] next_time;

  assign rows_cl = (rows_r == '0) ? SW'(1) :
                   ((32'(rows_r) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(rows_r));
  assign cols_cl = (cols_r == '0) ? SW'(1) :
                   ((32'(cols_r) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cols_r));
  assign n_now     = CW'(CW'(rows_cl) * CW'(cols_cl));
  assign pos_after = (load_pos_r < n_now) ? load_pos_r + CW'(1) : load_pos_r;

  assign in_ch.ready        = (state_r == S_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.escaped     = out_esc_r;
  assign out_ch.escape_time = out_time_r;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_valid_r & out_ch.ready;

  assign border = (cur_row_r == '0) || (cur_col_r == '0) ||
                  ((SW'(cur_row_r) + SW'(1)) == r_r) ||
                  ((SW'(cur_col_r) + SW'(1)) == c_r);

  always_comb begin
    case (dir_r)
      2'd0:    nb_out = (SW'(cur_row_r) + SW'(1)) == r_r;
      2'd1:    nb_out = (SW'(cur_col_r) + SW'(1)) == c_r;
      2'd2:    nb_out = (cur_row_r == '0);
      default: nb_out = (cur_col_r == '0);
    endcase
  end

  // stored kinds past the loaded count read as empty
  assign seed_kind = (seed_i_r < loaded_r) ? cell_rdata : KIND_EMPTY;
  assign nb_kind   = (CW'(ni_r) < loaded_r) ? cell_rdata : KIND_EMPTY;
  assign next_time = cur_time_r + TW'(1);

  always_comb begin
    state_nxt    = state_r;
    load_pos_nxt = load_pos_r;
    out_valid_nxt = out_valid_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    walker_nxt   = walker_r;
    seed_i_nxt   = seed_i_r;
    dir_nxt      = dir_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    n_nxt        = n_r;
    loaded_nxt   = loaded_r;
    srow_nxt     = srow_r;
    scol_nxt     = scol_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cur_idx_nxt  = cur_idx_r;
    cur_time_nxt = cur_time_r;
    ni_nxt       = ni_r;
    nr_nxt       = nr_r;
    nc_nxt       = nc_r;
    out_esc_nxt  = out_esc_r;
    out_time_nxt = out_time_r;

    cell_we    = 1'b0;
    cell_waddr = load_pos_r[IW-1:0];
    cell_wdata = in_ch.cell_kind;
    hz_we      = 1'b0;
    wk_we      = 1'b0;
    tm_waddr   = seed_i_r[IW-1:0];
    tm_wdata   = '0;
    rd_addr    = seed_i_r[IW-1:0];
    q_we       = 1'b0;
    q_wdata    = {srow_r, scol_r};

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cell_we      = (load_pos_r < n_now);
          load_pos_nxt = pos_after;
          if (in_ch.last_cell) begin
            r_nxt        = rows_cl;
            c_nxt        = cols_cl;
            n_nxt        = n_now;
            loaded_nxt   = (pos_after < n_now) ? pos_after : n_now;
            load_pos_nxt = '0;
            seed_i_nxt   = '0;
            walker_nxt   = 1'b0;
            state_nxt    = S_CLR;
          end
        end
      end
      S_CLR: begin
        hz_we      = 1'b1;
        wk_we      = 1'b1;
        seed_i_nxt = seed_i_r + CW'(1);
        if (seed_i_r + CW'(1) == n_r) begin
          seed_i_nxt = '0;
          srow_nxt   = '0;
          scol_nxt   = '0;
          head_nxt   = '0;
          tail_nxt   = '0;
          state_nxt  = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        state_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        tm_wdata = TW'(1);
        if (seed_kind == (walker_r ? KIND_START : KIND_SOURCE)) begin
          hz_we    = ~walker_r;
          wk_we    = walker_r;
          q_we     = 1'b1;
          tail_nxt = tail_r + CW'(1);
        end
        if (SW'(scol_r) + SW'(1) == c_r) begin
          scol_nxt = '0;
          srow_nxt = srow_r + AW'(1);
        end else begin
          scol_nxt = scol_r + AW'(1);
        end
        seed_i_nxt = seed_i_r + CW'(1);
        state_nxt  = (seed_i_r + CW'(1) == n_r) ? S_POP : S_SEED_RD;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          if (walker_r) begin
            out_valid_nxt = 1'b1;
            out_esc_nxt   = 1'b0;
            out_time_nxt  = '0;
            state_nxt     = S_OUT;
          end else begin
            // hazard spread done: seed the walker search
            walker_nxt = 1'b1;
            seed_i_nxt = '0;
            srow_nxt   = '0;
            scol_nxt   = '0;
            head_nxt   = '0;
            tail_nxt   = '0;
            state_nxt  = S_SEED_RD;
          end
        end else begin
          head_nxt  = head_r + CW'(1);
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        cur_row_nxt = q_rdata[QW-1:AW];
        cur_col_nxt = q_rdata[AW-1:0];
        state_nxt   = S_IDX;
      end
      S_IDX: begin
        cur_idx_nxt = IW'(IW'(cur_row_r) * IW'(c_r)) + IW'(cur_col_r);
        state_nxt   = S_CUR_RD;
      end
      S_CUR_RD: begin
        rd_addr   = cur_idx_r;
        state_nxt = S_CUR_W;
      end
      S_CUR_W: begin
        cur_time_nxt = walker_r ? wk_rdata : hz_rdata;
        dir_nxt      = 2'd0;
        if (walker_r && border) begin
          out_valid_nxt = 1'b1;
          out_esc_nxt   = 1'b1;
          out_time_nxt  = TIME_W'(wk_rdata);
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (nb_out) begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = (dir_r == 2'd3) ? S_POP : S_NB;
        end else begin
          case (dir_r)
            2'd0: begin
              ni_nxt = cur_idx_r + IW'(c_r);
              nr_nxt = cur_row_r + AW'(1);
              nc_nxt = cur_col_r;
            end
            2'd1: begin
              ni_nxt = cur_idx_r + IW'(1);
              nr_nxt = cur_row_r;
              nc_nxt = cur_col_r + AW'(1);
            end
            2'd2: begin
              ni_nxt = cur_idx_r - IW'(c_r);
              nr_nxt = cur_row_r - AW'(1);
              nc_nxt = cur_col_r;
            end
            default: begin
              ni_nxt = cur_idx_r - IW'(1);
              nr_nxt = cur_row_r;
              nc_nxt = cur_col_r - AW'(1);
            end
          endcase
          state_nxt = S_NB_RD;
        end
      end
      S_NB_RD: begin
        rd_addr   = ni_r;
        state_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        tm_waddr = ni_r;
        tm_wdata = next_time;
        q_wdata  = {nr_r, nc_r};
        if (walker_r) begin
          if (nb_kind != KIND_WALL && nb_kind != KIND_SOURCE && wk_rdata == '0 &&
              !(hz_rdata != '0 && hz_rdata <= next_time)) begin
            wk_we    = 1'b1;
            q_we     = 1'b1;
            tail_nxt = tail_r + CW'(1);
          end
        end else begin
          if (hz_rdata == '0 && nb_kind != KIND_WALL) begin
            hz_we    = 1'b1;
            q_we     = 1'b1;
            tail_nxt = tail_r + CW'(1);
          end
        end
        dir_nxt   = dir_r + 2'd1;
        state_nxt = (dir_r == 2'd3) ? S_POP : S_NB;
      end
      S_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_pos_r  <= '0;
      rows_r      <= CFG_W'(1);
      cols_r      <= CFG_W'(1);
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      walker_r    <= 1'b0;
      seed_i_r    <= '0;
      dir_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      walker_r    <= walker_nxt;
      seed_i_r    <= seed_i_nxt;
      dir_r       <= dir_nxt;
      if (cfg_we && cfg_addr == REG_ROWS) begin
        rows_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_COLS) begin
        cols_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    n_r        <= n_nxt;
    loaded_r   <= loaded_nxt;
    srow_r     <= srow_nxt;
    scol_r     <= scol_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_time_r <= cur_time_nxt;
    ni_r       <= ni_nxt;
    nr_r       <= nr_nxt;
    nc_r       <= nc_nxt;
    out_esc_r  <= out_esc_nxt;
    out_time_r <= out_time_nxt;
  end

  feg_ram #(.WIDTH(KIND_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (rd_addr),
    .rdata (cell_rdata)
  );

  feg_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_hz_ram (
    .clk   (clk),
    .we    (hz_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (rd_addr),
    .rdata (hz_rdata)
  );

  feg_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_wk_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (rd_addr),
    .rdata (wk_rdata)
  );

  feg_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r[IW-1:0]),
    .wdata (q_wdata),
    .raddr (head_r[IW-1:0]),
    .rdata (q_rdata)
  );
endmodule

FILE: rtl/feg_chk.sv
// ----------------------------------------------------------------------------
// feg_chk
// Port-level checks for the fire-escape grid search block.
// ----------------------------------------------------------------------------
module feg_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_escaped,
  input logic [feg_pkg::TIME_W-1:0] out_time
);
  import feg_pkg::*;

  // a grid is never loaded while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("in_ready with pending result");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input taken during search");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_escaped) |-> (out_time == '0))
    else $error("nonzero time on impossible result");

  a_esc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_escaped) |-> (out_time != '0))
    else $error("zero exit time on escaped result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_escaped) && $stable(out_time)))
    else $error("result dropped while stalled");
endmodule

bind fire_escape_grid_bfs_top feg_chk u_feg_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_cell),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_escaped (out_ch.escaped),
  .out_time    (out_ch.escape_time)
);
